### rtl/core/rtwc_pkg.sv
// Package for the route time window check: widths, codes, control word
// layout and the control program of the sequencer.
// No dependencies; every other file of the block imports it.
`default_nettype none

package rtwc_pkg;

    // Field widths
    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 8;
    localparam int T_W        = 32;
    localparam int DEM_W      = 16;
    localparam int LOAD_W     = 17;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Square root sizing: radicand is (dx^2 + dy^2) scaled by 2^(2*FRAC_BITS)
    localparam int SQ_W     = 2 * COORD_BITS + 1;
    localparam int RAD_W    = SQ_W + 2 * FRAC_BITS;
    localparam int ROOT_W   = (RAD_W + 1) / 2;
    localparam int RAD_PAD  = 2 * ROOT_W;
    localparam int CNT_W    = $clog2(ROOT_W);
    localparam int LEG_W    = (ROOT_W > T_W) ? ROOT_W : T_W;

    localparam logic [T_W-1:0]    T_MAX    = '1;
    localparam logic [LOAD_W-1:0] LOAD_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEPOT_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPOT_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUR  = 2'd3;

    // Sticky route status
    typedef enum logic [STAT_W-1:0] {
        FAIL_NONE   = 2'd0,
        FAIL_CAP    = 2'd1,
        FAIL_WINDOW = 2'd2,
        FAIL_DUR    = 2'd3
    } t_fail;

    // Datapath operations, one per control word
    typedef enum logic [3:0] {
        U_NOP,
        U_IDLE,
        U_LEG_DIFF,
        U_BACK_DIFF,
        U_SQ_X,
        U_SQ_Y,
        U_SQRT_GO,
        U_SQRT_WAIT,
        U_LEG_ACC,
        U_START,
        U_DEPART,
        U_BACK_ACC,
        U_DUR_CHECK,
        U_OUT
    } t_uop;

    // Jump conditions
    typedef enum logic [2:0] {
        J_NONE,
        J_ALWAYS,
        J_NO_INPUT,
        J_SQRT_BUSY,
        J_NOT_LAST,
        J_OUT_BUSY
    } t_jcond;

    localparam int PC_W = 5;

    typedef struct packed {
        t_uop             op;
        t_jcond           jcond;
        logic [PC_W-1:0]  target;
    } t_uword;

    // Status fed back from the datapath to the sequencer
    typedef struct packed {
        logic in_accept;
        logic sqrt_busy;
        logic last;
        logic out_busy;
    } t_seq_stat;

    // Program step addresses; the output step sits at the top so that
    // falling through it wraps back to idle
    localparam logic [PC_W-1:0] ST_IDLE       = 5'd0;
    localparam logic [PC_W-1:0] ST_LEG_DIFF   = 5'd1;
    localparam logic [PC_W-1:0] ST_LEG_SQX    = 5'd2;
    localparam logic [PC_W-1:0] ST_LEG_SQY    = 5'd3;
    localparam logic [PC_W-1:0] ST_LEG_GO     = 5'd4;
    localparam logic [PC_W-1:0] ST_LEG_WAIT   = 5'd5;
    localparam logic [PC_W-1:0] ST_LEG_ACC    = 5'd6;
    localparam logic [PC_W-1:0] ST_START      = 5'd7;
    localparam logic [PC_W-1:0] ST_DEPART     = 5'd8;
    localparam logic [PC_W-1:0] ST_BACK_DIFF  = 5'd9;
    localparam logic [PC_W-1:0] ST_BACK_SQX   = 5'd10;
    localparam logic [PC_W-1:0] ST_BACK_SQY   = 5'd11;
    localparam logic [PC_W-1:0] ST_BACK_GO    = 5'd12;
    localparam logic [PC_W-1:0] ST_BACK_WAIT  = 5'd13;
    localparam logic [PC_W-1:0] ST_BACK_ACC   = 5'd14;
    localparam logic [PC_W-1:0] ST_DUR_CHECK  = 5'd15;
    localparam logic [PC_W-1:0] ST_OUT        = 5'd31;

    // Control program ROM
    function automatic t_uword uprog(input logic [PC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            ST_IDLE:      w = '{U_IDLE,      J_NO_INPUT,  ST_IDLE};
            ST_LEG_DIFF:  w = '{U_LEG_DIFF,  J_NONE,      ST_IDLE};
            ST_LEG_SQX:   w = '{U_SQ_X,      J_NONE,      ST_IDLE};
            ST_LEG_SQY:   w = '{U_SQ_Y,      J_NONE,      ST_IDLE};
            ST_LEG_GO:    w = '{U_SQRT_GO,   J_NONE,      ST_IDLE};
            ST_LEG_WAIT:  w = '{U_SQRT_WAIT, J_SQRT_BUSY, ST_LEG_WAIT};
            ST_LEG_ACC:   w = '{U_LEG_ACC,   J_NONE,      ST_IDLE};
            ST_START:     w = '{U_START,     J_NONE,      ST_IDLE};
            ST_DEPART:    w = '{U_DEPART,    J_NOT_LAST,  ST_OUT};
            ST_BACK_DIFF: w = '{U_BACK_DIFF, J_NONE,      ST_IDLE};
            ST_BACK_SQX:  w = '{U_SQ_X,      J_NONE,      ST_IDLE};
            ST_BACK_SQY:  w = '{U_SQ_Y,      J_NONE,      ST_IDLE};
            ST_BACK_GO:   w = '{U_SQRT_GO,   J_NONE,      ST_IDLE};
            ST_BACK_WAIT: w = '{U_SQRT_WAIT, J_SQRT_BUSY, ST_BACK_WAIT};
            ST_BACK_ACC:  w = '{U_BACK_ACC,  J_NONE,      ST_IDLE};
            ST_DUR_CHECK: w = '{U_DUR_CHECK, J_ALWAYS,    ST_OUT};
            ST_OUT:       w = '{U_OUT,       J_OUT_BUSY,  ST_OUT};
            default:      w = '{U_NOP,       J_ALWAYS,    ST_IDLE};
        endcase
        return w;
    endfunction

    // Saturating add of two time values
    function automatic logic [T_W-1:0] sat_add(input logic [T_W-1:0] a,
                                                input logic [T_W-1:0] b);
        logic [T_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[T_W] ? T_MAX : s[T_W-1:0];
    endfunction

    // Absolute difference of two coordinates
    function automatic logic [COORD_BITS-1:0] abs_diff(input logic [COORD_BITS-1:0] a,
                                                       input logic [COORD_BITS-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

`default_nettype wire

### rtl/core/rtwc_sqrt.sv
// Iterative floor square root, one result bit per cycle (restoring method).
// Depends on rtwc_pkg for the radicand and root widths.
`default_nettype none

module rtwc_sqrt
    import rtwc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [RAD_W-1:0]  i_rad,
    output logic                   o_busy,
    output logic [ROOT_W-1:0]      o_root
);

    logic [RAD_PAD-1:0] r_rad;
    logic [ROOT_W:0]    r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;

    logic [ROOT_W+2:0]  c_rem_sh;
    logic [ROOT_W+2:0]  c_trial;
    logic [ROOT_W+2:0]  c_diff;
    logic               c_ge;

    // Bring down two radicand bits and try the next root bit
    always_comb begin
        c_rem_sh = {r_rem, r_rad[RAD_PAD-1 -: 2]};
        c_trial  = {1'b0, r_root, 2'b01};
        c_diff   = c_rem_sh - c_trial;
        c_ge     = (c_rem_sh >= c_trial);
    end

    // Control: busy from a start until the last root bit is computed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(ROOT_W - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= RAD_PAD'(i_rad);
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= r_rad << 2;
            r_rem  <= c_ge ? c_diff[ROOT_W:0] : c_rem_sh[ROOT_W:0];
            r_root <= {r_root[ROOT_W-2:0], c_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

    // A new root must never be started on top of a running one
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("square root restarted while busy");

endmodule

`default_nettype wire

### rtl/core/rtwc_sequencer.sv
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
// Depends on rtwc_pkg for the control word, program and status struct.
`default_nettype none

module rtwc_sequencer
    import rtwc_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_seq_stat i_stat,
    output t_uop           o_op
);

    logic [PC_W-1:0] r_pc;
    logic [PC_W-1:0] n_pc;
    t_uword          c_word;
    logic            c_take;

    // Fetch current control word
    assign c_word = uprog(r_pc);

    // Jump condition decode
    always_comb begin
        unique case (c_word.jcond)
            J_NONE:      c_take = 1'b0;
            J_ALWAYS:    c_take = 1'b1;
            J_NO_INPUT:  c_take = !i_stat.in_accept;
            J_SQRT_BUSY: c_take = i_stat.sqrt_busy;
            J_NOT_LAST:  c_take = !i_stat.last;
            J_OUT_BUSY:  c_take = i_stat.out_busy;
            default:     c_take = 1'b1;
        endcase
    end

    // Next step: jump target or fall through (wraps from the output step)
    always_comb begin
        n_pc = c_take ? c_word.target : r_pc + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_op = c_word.op;

endmodule

`default_nettype wire

### rtl/core/rtwc_datapath.sv
// Datapath of the route check: config registers, route state, one shared
// multiplier, saturating adders and the result register.
// Depends on rtwc_pkg; driven by rtwc_sequencer, uses rtwc_sqrt results.
`default_nettype none

module rtwc_datapath
    import rtwc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire t_uop                   i_op,
    output t_seq_stat                   o_stat,
    // configuration
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // square root unit
    output logic                        o_sqrt_start,
    output logic [RAD_W-1:0]            o_sqrt_rad,
    input  wire logic                   i_sqrt_busy,
    input  wire logic [ROOT_W-1:0]      i_sqrt_root,
    // input channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [COORD_BITS-1:0]  i_cust_x,
    input  wire logic [COORD_BITS-1:0]  i_cust_y,
    input  wire logic [DEM_W-1:0]       i_demand,
    input  wire logic [T_W-1:0]         i_service_time,
    input  wire logic [T_W-1:0]         i_window_open,
    input  wire logic [T_W-1:0]         i_window_close,
    input  wire logic                   i_last_customer,
    // output channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [T_W-1:0]              o_service_start,
    output logic [T_W-1:0]              o_departure_time,
    output logic [LOAD_W-1:0]           o_load_so_far,
    output logic [T_W-1:0]              o_route_distance,
    output logic [T_W-1:0]              o_return_time,
    output logic [STAT_W-1:0]           o_status,
    output logic                        o_route_done
);

    // Configuration registers
    logic [COORD_BITS-1:0] r_depot_x;
    logic [COORD_BITS-1:0] r_depot_y;
    logic [DEM_W-1:0]      r_capacity;
    logic [T_W-1:0]        r_max_dur;

    // Route state
    logic [T_W-1:0]        r_clock;
    logic [LOAD_W-1:0]     r_load;
    logic [COORD_BITS-1:0] r_prev_x;
    logic [COORD_BITS-1:0] r_prev_y;
    logic [T_W-1:0]        r_dist;
    t_fail                 r_fail;
    logic                  r_in_route;

    // Current transaction
    logic [COORD_BITS-1:0] r_cx;
    logic [COORD_BITS-1:0] r_cy;
    logic [DEM_W-1:0]      r_dem;
    logic [T_W-1:0]        r_svc;
    logic [T_W-1:0]        r_wopen;
    logic [T_W-1:0]        r_wclose;
    logic                  r_last;

    // Working registers
    logic [COORD_BITS-1:0] r_dx;
    logic [COORD_BITS-1:0] r_dy;
    logic [SQ_W-1:0]       r_sq;
    logic [T_W-1:0]        r_start;
    logic [T_W-1:0]        r_depart;
    logic [T_W-1:0]        r_ret;

    // Result register
    logic                  r_out_valid;
    logic [T_W-1:0]        r_o_start;
    logic [T_W-1:0]        r_o_depart;
    logic [LOAD_W-1:0]     r_o_load;
    logic [T_W-1:0]        r_o_dist;
    logic [T_W-1:0]        r_o_ret;
    logic [STAT_W-1:0]     r_o_status;
    logic                  r_o_done;

    logic                    c_in_accept;
    logic                    c_out_busy;
    logic                    c_out_fire;
    logic                    c_clear;
    logic [COORD_BITS-1:0]   c_ax;
    logic [COORD_BITS-1:0]   c_ay;
    logic [COORD_BITS-1:0]   c_bx;
    logic [COORD_BITS-1:0]   c_by;
    logic [COORD_BITS-1:0]   c_mul_in;
    logic [2*COORD_BITS-1:0] c_prod;
    logic [LOAD_W:0]         c_load_sum;
    logic [LOAD_W-1:0]       c_load_new;
    logic [LEG_W-1:0]        c_root_ext;
    logic [T_W-1:0]          c_leg;
    logic [T_W-1:0]          c_start_max;
    logic [T_W-1:0]          c_depart;

    // Handshake and status
    assign o_in_ready  = (i_op == U_IDLE);
    assign c_in_accept = i_in_valid && o_in_ready;
    assign c_out_busy  = r_out_valid && !i_out_ready;
    assign c_out_fire  = (i_op == U_OUT) && !c_out_busy;
    assign c_clear     = c_out_fire && r_last;

    assign o_stat = '{in_accept: c_in_accept,
                      sqrt_busy: i_sqrt_busy,
                      last:      r_last,
                      out_busy:  c_out_busy};

    // Leg end points: previous position to customer, or customer to depot
    always_comb begin
        if (i_op == U_BACK_DIFF) begin
            c_ax = r_cx;
            c_ay = r_cy;
            c_bx = r_depot_x;
            c_by = r_depot_y;
        end else begin
            c_ax = r_prev_x;
            c_ay = r_prev_y;
            c_bx = r_cx;
            c_by = r_cy;
        end
    end

    // Shared squarer
    assign c_mul_in = (i_op == U_SQ_Y) ? r_dy : r_dx;
    assign c_prod   = c_mul_in * c_mul_in;

    // Square root interface: scale by 2^(2*FRAC_BITS) so the root comes out in Q.FRAC_BITS
    assign o_sqrt_start = (i_op == U_SQRT_GO);
    assign o_sqrt_rad   = {r_sq, {(2*FRAC_BITS){1'b0}}};

    // Leg length, saturated to the time width
    always_comb begin
        c_root_ext = LEG_W'(i_sqrt_root);
        c_leg      = (c_root_ext > LEG_W'(T_MAX)) ? T_MAX : c_root_ext[T_W-1:0];
    end

    // Load accumulation with saturation
    always_comb begin
        c_load_sum = {1'b0, r_load} + (LOAD_W+1)'(r_dem);
        c_load_new = (c_load_sum > (LOAD_W+1)'(LOAD_MAX)) ? LOAD_MAX
                                                         : c_load_sum[LOAD_W-1:0];
    end

    // Service start and departure
    assign c_start_max = (r_start > r_wopen) ? r_start : r_wopen;
    assign c_depart    = sat_add(r_start, r_svc);

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depot_x  <= '0;
            r_depot_y  <= '0;
            r_capacity <= '1;
            r_max_dur  <= T_MAX;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DEPOT_X:  r_depot_x  <= i_cfg_wdata[COORD_BITS-1:0];
                CFG_DEPOT_Y:  r_depot_y  <= i_cfg_wdata[COORD_BITS-1:0];
                CFG_CAPACITY: r_capacity <= i_cfg_wdata[DEM_W-1:0];
                CFG_MAX_DUR:  r_max_dur  <= i_cfg_wdata[T_W-1:0];
                default:      ;
            endcase
        end
    end

    // Route state, updated by the micro-operations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock    <= '0;
            r_load     <= '0;
            r_prev_x   <= '0;
            r_prev_y   <= '0;
            r_dist     <= '0;
            r_fail     <= FAIL_NONE;
            r_in_route <= 1'b0;
        end else begin
            unique case (i_op)
                U_IDLE: begin
                    // first customer of a route starts from the depot
                    if (c_in_accept && !r_in_route) begin
                        r_prev_x <= r_depot_x;
                        r_prev_y <= r_depot_y;
                    end
                end
                U_LEG_DIFF: begin
                    r_load <= c_load_new;
                    if (r_fail == FAIL_NONE && c_load_new > LOAD_W'(r_capacity)) begin
                        r_fail <= FAIL_CAP;
                    end
                end
                U_LEG_ACC: begin
                    r_dist <= sat_add(r_dist, c_leg);
                end
                U_START: begin
                    if (r_fail == FAIL_NONE && c_start_max > r_wclose) begin
                        r_fail <= FAIL_WINDOW;
                    end
                end
                U_DEPART: begin
                    r_clock    <= c_depart;
                    r_prev_x   <= r_cx;
                    r_prev_y   <= r_cy;
                    r_in_route <= 1'b1;
                end
                U_BACK_ACC: begin
                    r_dist <= sat_add(r_dist, c_leg);
                end
                U_DUR_CHECK: begin
                    if (r_fail == FAIL_NONE && r_ret > r_max_dur) begin
                        r_fail <= FAIL_DUR;
                    end
                end
                U_OUT: begin
                    // end of route: clock, load, distance, status and route flag back to the reset values
                    if (c_clear) begin
                        r_clock    <= '0;
                        r_load     <= '0;
                        r_dist     <= '0;
                        r_fail     <= FAIL_NONE;
                        r_in_route <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Transaction and working registers (no reset needed)
    always_ff @(posedge i_clk) begin
        if (c_in_accept) begin
            r_cx     <= i_cust_x;
            r_cy     <= i_cust_y;
            r_dem    <= i_demand;
            r_svc    <= i_service_time;
            r_wopen  <= i_window_open;
            r_wclose <= i_window_close;
            r_last   <= i_last_customer;
        end
        case (i_op)
            U_LEG_DIFF, U_BACK_DIFF: begin
                r_dx <= abs_diff(c_ax, c_bx);
                r_dy <= abs_diff(c_ay, c_by);
            end
            U_SQ_X:     r_sq     <= SQ_W'(c_prod);
            U_SQ_Y:     r_sq     <= r_sq + SQ_W'(c_prod);
            U_LEG_ACC:  r_start  <= sat_add(r_clock, c_leg);
            U_START:    r_start  <= c_start_max;
            U_DEPART:   r_depart <= c_depart;
            U_BACK_ACC: r_ret    <= sat_add(r_depart, c_leg);
            default:    ;
        endcase
    end

    // Result register: holds until taken, frees the sequencer meanwhile
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (c_out_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_out_fire) begin
            r_o_start  <= r_start;
            r_o_depart <= r_depart;
            r_o_load   <= r_load;
            r_o_dist   <= r_dist;
            r_o_ret    <= r_last ? r_ret : '0;
            r_o_status <= r_fail;
            r_o_done   <= r_last;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_service_start  = r_o_start;
    assign o_departure_time = r_o_depart;
    assign o_load_so_far    = r_o_load;
    assign o_route_distance = r_o_dist;
    assign o_return_time    = r_o_ret;
    assign o_status         = r_o_status;
    assign o_route_done     = r_o_done;

    // Status is sticky until the route ends
    a_fail_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fail != FAIL_NONE && !c_clear) |=> (r_fail == $past(r_fail)))
        else $error("route status changed after a failure");

    // Service never starts before the window opens
    a_start_after_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_out_fire |-> (r_start >= r_wopen))
        else $error("service start before window open");

    // Departure never precedes service start
    a_depart_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_out_fire |-> (r_depart >= r_start))
        else $error("departure earlier than service start");

    // The last customer closes the route
    a_route_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_clear |=> (!r_in_route && r_load == '0 && r_clock == '0))
        else $error("route state not cleared after last customer");

endmodule

`default_nettype wire

### rtl/core/route_time_window_check_unit.sv
// Per customer: leg difference, squares, 21-step iterative square root, leg
// distance, service start and departure; the last customer of a route adds the
// leg back to the depot and a duration check. The next transaction is taken in
// the cycle after the result is registered, while it waits in its own register.
// Synchronous active-low reset: config to defaults, route at the depot.
// Top level: joins sequencer, datapath and square root unit; uses rtwc_pkg.
`default_nettype none

module route_time_window_check_unit
    import rtwc_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_wdata,
    // input channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [COORD_BITS-1:0]  i_cust_x,
    input  wire logic [COORD_BITS-1:0]  i_cust_y,
    input  wire logic [DEM_W-1:0]       i_demand,
    input  wire logic [T_W-1:0]         i_service_time,
    input  wire logic [T_W-1:0]         i_window_open,
    input  wire logic [T_W-1:0]         i_window_close,
    input  wire logic                   i_last_customer,
    // output channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [T_W-1:0]              o_service_start,
    output logic [T_W-1:0]              o_departure_time,
    output logic [LOAD_W-1:0]           o_load_so_far,
    output logic [T_W-1:0]              o_route_distance,
    output logic [T_W-1:0]              o_return_time,
    output logic [STAT_W-1:0]           o_status,
    output logic                        o_route_done
);

    t_uop              w_op;
    t_seq_stat         w_stat;
    logic              w_sqrt_start;
    logic [RAD_W-1:0]  w_sqrt_rad;
    logic              w_sqrt_busy;
    logic [ROOT_W-1:0] w_sqrt_root;

    // Control program
    rtwc_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_op    (w_op)
    );

    // Shared square root
    rtwc_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_rad   (w_sqrt_rad),
        .o_busy  (w_sqrt_busy),
        .o_root  (w_sqrt_root)
    );

    // Datapath
    rtwc_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (w_op),
        .o_stat           (w_stat),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .o_sqrt_start     (w_sqrt_start),
        .o_sqrt_rad       (w_sqrt_rad),
        .i_sqrt_busy      (w_sqrt_busy),
        .i_sqrt_root      (w_sqrt_root),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cust_x         (i_cust_x),
        .i_cust_y         (i_cust_y),
        .i_demand         (i_demand),
        .i_service_time   (i_service_time),
        .i_window_open    (i_window_open),
        .i_window_close   (i_window_close),
        .i_last_customer  (i_last_customer),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_service_start  (o_service_start),
        .o_departure_time (o_departure_time),
        .o_load_so_far    (o_load_so_far),
        .o_route_distance (o_route_distance),
        .o_return_time    (o_return_time),
        .o_status         (o_status),
        .o_route_done     (o_route_done)
    );

endmodule

`default_nettype wire
